>>> src/integer_deque_macros.svh
// ----------------------------------------------------------------------------
// integer_deque_macros.svh
// Assertion macros used by the integer deque datapath.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DEQUE_MACROS_SVH
`define INTEGER_DEQUE_MACROS_SVH

// A property that is checked on every rising clock edge outside reset.
`define IDEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that is checked on every rising clock edge outside reset.
`define IDEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ideq_pkg.sv
// ----------------------------------------------------------------------------
// ideq_pkg
// Types and constants shared by the integer deque modules.
// ----------------------------------------------------------------------------
package ideq_pkg;

  // Default number of entries in the ring store.
  localparam int DEPTH_DEF = 64;

  // Field widths of the stream payloads.
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = VALUE_W + STATUS_W + COUNT_OUT_W + 1 + VALUE_W + VALUE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input transfer happens this cycle
    logic fix;       // memory read data is valid and may refresh an end value
    logic load_out;  // capture the result into the output register
  } cmd_t;

endpackage

>>> src/ideq_ctrl.sv
// ----------------------------------------------------------------------------
// ideq_ctrl
// Controller of the integer deque: sequences accept, read fix-up and result
// hand-over, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ideq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output ideq_pkg::cmd_t cmd_o
);

  // One-hot controller states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIX  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next-state and command logic.
  always_comb begin
    state_d      = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.fix      = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register empties on a transfer and fills on a load.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;

endmodule

>>> src/ideq_dpath.sv
// ----------------------------------------------------------------------------
// ideq_dpath
// Datapath of the integer deque: ring store, head pointer, occupancy count,
// cached front and back values and the output register.
// ----------------------------------------------------------------------------
`include "integer_deque_macros.svh"

module ideq_dpath #(
  parameter int DEPTH = ideq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ideq_pkg::cmd_t                     cmd_i,
  input  logic [ideq_pkg::IN_TUSER_W-1:0]    op_i,
  input  logic [ideq_pkg::VALUE_W-1:0]       value_i,
  output logic [ideq_pkg::OUT_TDATA_W-1:0]   out_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int VW    = ideq_pkg::VALUE_W;

  // Ring store, written and read in clocked blocks.
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [VW-1:0]    front_q, front_d;
  logic [VW-1:0]    back_q, back_d;
  logic [VW-1:0]    popped_q, popped_d;
  ideq_pkg::status_e status_q, status_d;
  logic             fix_front_q, fix_front_d;
  logic             fix_back_q, fix_back_d;
  logic [ideq_pkg::OUT_TDATA_W-1:0] out_q;

  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] raddr;
  logic             is_full;
  logic             is_zero;
  logic [SUM_W-1:0] head_ext;
  logic [SUM_W-1:0] cnt_ext;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_idx;
  logic [PTR_W-1:0] last2_idx;
  logic [CNT_W+ideq_pkg::COUNT_OUT_W-1:0] cnt_wide;
  logic             out_empty;

  // Folds a sum below twice the depth back into the ring.
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (r >= SUM_W'(DEPTH)) begin
      r = r - SUM_W'(DEPTH);
    end
    return r[PTR_W-1:0];
  endfunction

  // Ring positions derived from the head and the count.
  always_comb begin
    head_ext  = SUM_W'(head_q);
    cnt_ext   = SUM_W'(count_q);
    is_full   = (count_q == CNT_W'(DEPTH));
    is_zero   = (count_q == '0);
    head_dec  = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
    head_inc  = wrap(head_ext + SUM_W'(1));
    tail_idx  = wrap(head_ext + cnt_ext);
    last2_idx = wrap(head_ext + cnt_ext - SUM_W'(2));
  end

  // Operation decode: state update at the transfer, end value fix-up after the read.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    popped_d    = popped_q;
    status_d    = status_q;
    fix_front_d = fix_front_q;
    fix_back_d  = fix_back_q;
    we          = 1'b0;
    waddr       = head_dec;
    raddr       = head_inc;
    if (cmd_i.accept) begin
      status_d    = ideq_pkg::ST_OK;
      popped_d    = '0;
      fix_front_d = 1'b0;
      fix_back_d  = 1'b0;
      case (ideq_pkg::op_e'(op_i))
        ideq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ideq_pkg::ST_OVER;
          end else begin
            head_d  = head_dec;
            we      = 1'b1;
            waddr   = head_dec;
            front_d = value_i;
            if (is_zero) begin
              back_d = value_i;
            end
            count_d = count_q + 1'b1;
          end
        end
        ideq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = ideq_pkg::ST_OVER;
          end else begin
            we     = 1'b1;
            waddr  = tail_idx;
            back_d = value_i;
            if (is_zero) begin
              front_d = value_i;
            end
            count_d = count_q + 1'b1;
          end
        end
        ideq_pkg::OP_POP_FRONT: begin
          if (is_zero) begin
            status_d = ideq_pkg::ST_UNDER;
          end else begin
            popped_d    = front_q;
            head_d      = head_inc;
            raddr       = head_inc;
            count_d     = count_q - 1'b1;
            fix_front_d = (count_q > CNT_W'(1));
          end
        end
        ideq_pkg::OP_POP_BACK: begin
          if (is_zero) begin
            status_d = ideq_pkg::ST_UNDER;
          end else begin
            popped_d   = back_q;
            raddr      = last2_idx;
            count_d    = count_q - 1'b1;
            fix_back_d = (count_q > CNT_W'(1));
          end
        end
        default: begin
          status_d = ideq_pkg::ST_OK;
        end
      endcase
    end
    if (cmd_i.fix) begin
      if (fix_front_q) begin
        front_d = rd_q;
      end
      if (fix_back_q) begin
        back_d = rd_q;
      end
    end
  end

  // Ring store write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_i;
    end
    rd_q <= mem[raddr];
  end

  // Pointer and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    popped_q    <= popped_d;
    status_q    <= status_d;
    fix_front_q <= fix_front_d;
    fix_back_q  <= fix_back_d;
  end

  // Result packing into the output register.
  always_comb begin
    cnt_wide  = (CNT_W + ideq_pkg::COUNT_OUT_W)'(count_q);
    out_empty = (count_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {{ideq_pkg::OUT_PAD_W{1'b0}},
                (out_empty ? {VW{1'b0}} : back_q),
                (out_empty ? {VW{1'b0}} : front_q),
                out_empty,
                cnt_wide[ideq_pkg::COUNT_OUT_W-1:0],
                status_q,
                popped_q};
    end
  end

  assign out_data_o = out_q;

  // The count never exceeds the ring size.
  `IDEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "count beyond depth")

  // A pop on an empty ring reports underflow and leaves the count alone.
  `IDEQ_ASSERT_IMP(a_underflow, clk_i, rst_ni,
    cmd_i.accept && is_zero && (op_i == ideq_pkg::OP_POP_FRONT || op_i == ideq_pkg::OP_POP_BACK),
    status_q == ideq_pkg::ST_UNDER && $stable(count_q), "empty pop not flagged")

  // A push that fits raises the count by one.
  `IDEQ_ASSERT_IMP(a_push_count, clk_i, rst_ni,
    cmd_i.accept && !is_full && (op_i == ideq_pkg::OP_PUSH_FRONT || op_i == ideq_pkg::OP_PUSH_BACK),
    count_q == $past(count_q) + 1'b1, "push did not raise count")

endmodule

>>> src/integer_deque.sv
// ----------------------------------------------------------------------------
// integer_deque
// Double-ended queue of signed 32-bit integers held in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transfer carries one operation on tuser (push front, push
//   back, pop front, pop back) and the value to push on tdata. Each operation
//   yields exactly one master-side transfer holding the popped value, a status
//   (ok, underflow, overflow), the entry count, an empty flag and the front and
//   back values after the operation.
//   The result reaches the output register in steps: the transfer in the idle
//   state updates the ring and issues a memory read, the fix state lets the
//   registered read data refresh the front or back value, and the hold state
//   loads the result once the output register is free. The single read port
//   of the ring store and the cached end values call for these steps; the
//   block takes a new item only in the idle state, after the result of the
//   last one has been loaded.
//   A result waits in the output register while the receiver stalls; the
//   next item is still taken, and its result is held back until the output
//   register frees. Reset empties the queue and clears the output valid flag;
//   the ring contents need no clearing as only written entries are read.
// ----------------------------------------------------------------------------
module integer_deque #(
  parameter int DEPTH = ideq_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] value
  input  logic [ideq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [ideq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] popped_value, [33:32] status, [40:34] entry_count, [41] is_empty,
  // [73:42] front_value, [105:74] back_value, [111:106] zero
  output logic [ideq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  ideq_pkg::cmd_t cmd;

  // Controller.
  ideq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // Datapath.
  ideq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tuser),
    .value_i    (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the integer deque.
// A table of directed operations runs first: empty pops, end values and
// pointer wrap, with the obvious results written out by hand. A long random
// run then follows in fill, drain and mixed phases, so that the queue is
// driven to full and to empty many times. Every operation is mirrored in a
// bounded shadow queue, and each result transfer is compared with the oldest
// predicted result. The sender works in bursts, and the receiver stalls in
// patterns, with one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RING_DEPTH   = ideq_pkg::DEPTH_DEF;
  localparam int          N_RANDOM     = 650;
  localparam int          HOLD_AT      = 150;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 200000;

  localparam int VALUE_W     = ideq_pkg::VALUE_W;
  localparam int COUNT_OUT_W = ideq_pkg::COUNT_OUT_W;
  localparam int OUT_FIELD_W = ideq_pkg::OUT_FIELD_W;
  localparam int OUT_TDATA_W = ideq_pkg::OUT_TDATA_W;

  // One result, laid out so that the first field sits in the lowest bits.
  typedef struct packed {
    logic [VALUE_W-1:0]     back;
    logic [VALUE_W-1:0]     front;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count;
    ideq_pkg::status_e      status;
    logic [VALUE_W-1:0]     popped;
  } result_t;

  // One row of the directed table.
  typedef struct {
    ideq_pkg::op_e      op;
    logic [VALUE_W-1:0] value;
    logic               typed;
    result_t            want;
  } row_t;

  // Operation mix of a random phase.
  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  localparam result_t UNTYPED = '0;
  localparam int      N_DIR   = 22;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  logic [ideq_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
  logic [ideq_pkg::IN_TUSER_W-1:0]      s_axis_tuser;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  logic [OUT_TDATA_W-1:0]               m_axis_tdata;

  logic [VALUE_W-1:0] shadow_q [$];
  result_t            pending_results [$];
  row_t               dir_rows [N_DIR];
  int                 ops_sent;
  int                 burst_left;
  int                 mismatches;
  int unsigned        cycle_count;
  result_t            got_res;
  result_t            want_res;

  integer_deque #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Builds a result from its fields, for the hand-written table rows.
  function automatic result_t outcome(logic [VALUE_W-1:0] popped,
                                      ideq_pkg::status_e status,
                                      logic [COUNT_OUT_W-1:0] count, logic empty,
                                      logic [VALUE_W-1:0] front,
                                      logic [VALUE_W-1:0] back);
    result_t r;
    r.popped = popped;
    r.status = status;
    r.count  = count;
    r.empty  = empty;
    r.front  = front;
    r.back   = back;
    return r;
  endfunction

  // Applies one operation to the shadow queue and returns its result.
  function automatic result_t shadow_apply(ideq_pkg::op_e op, logic [VALUE_W-1:0] value);
    result_t r;
    r = '0;
    r.status = ideq_pkg::ST_OK;
    case (op)
      ideq_pkg::OP_PUSH_FRONT: begin
        if (shadow_q.size() >= RING_DEPTH) r.status = ideq_pkg::ST_OVER;
        else shadow_q.push_front(value);
      end
      ideq_pkg::OP_PUSH_BACK: begin
        if (shadow_q.size() >= RING_DEPTH) r.status = ideq_pkg::ST_OVER;
        else shadow_q.push_back(value);
      end
      ideq_pkg::OP_POP_FRONT: begin
        if (shadow_q.size() == 0) r.status = ideq_pkg::ST_UNDER;
        else r.popped = shadow_q.pop_front();
      end
      default: begin
        if (shadow_q.size() == 0) r.status = ideq_pkg::ST_UNDER;
        else r.popped = shadow_q.pop_back();
      end
    endcase
    r.count = COUNT_OUT_W'(shadow_q.size());
    r.empty = (shadow_q.size() == 0);
    if (shadow_q.size() != 0) begin
      r.front = shadow_q[0];
      r.back  = shadow_q[$];
    end
    return r;
  endfunction

  // A push value, weighted towards the extremes of the signed range.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return VALUE_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Offers one operation, waits for its transfer, records the expected result
  // and then applies the sender's burst and gap pattern.
  task automatic send_item(ideq_pkg::op_e op, logic [VALUE_W-1:0] value, logic typed,
                           result_t want);
    result_t predicted;
    int      gap;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = shadow_apply(op, value);
    pending_results.push_back(typed ? want : predicted);
    ops_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = $urandom;
        s_axis_tuser  = ideq_pkg::IN_TUSER_W'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = result_t'(m_axis_tdata[OUT_FIELD_W-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transfer: tdata=%h", m_axis_tdata);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.popped !== want_res.popped || got_res.status !== want_res.status ||
            got_res.count !== want_res.count || got_res.empty !== want_res.empty ||
            got_res.front !== want_res.front || got_res.back !== want_res.back ||
            m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected popped=%h status=%0d count=%0d empty=%b ",
                      "front=%h back=%h; got popped=%h status=%0d count=%0d ",
                      "empty=%b front=%h back=%h pad=%h"},
                     want_res.popped, want_res.status, want_res.count, want_res.empty,
                     want_res.front, want_res.back, got_res.popped, got_res.status,
                     got_res.count, got_res.empty, got_res.front, got_res.back,
                     m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
        end
      end
    end
  end

  // Receiver: stall patterns that change from stretch to stretch, with one
  // long hold-off so that the block fills up and stops taking input.
  initial begin
    int mode;
    int stretch;
    int tick;
    int held;
    bit hold_done;
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    tick          = 0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(20, 150);
      repeat (stretch) begin
        @(negedge clk_i);
        if (!hold_done && ops_sent >= HOLD_AT) begin
          hold_done     = 1'b1;
          m_axis_tready = 1'b0;
          for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        end
        tick++;
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = ($urandom_range(0, 3) != 0);
          2:       m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    int            sent;
    int            span;
    mix_e          mix;
    ideq_pkg::op_e op;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    ops_sent      = 0;
    burst_left    = 0;
    mismatches    = 0;
    cycle_count   = 0;

    // Directed table. The first rows cover empty pops and both extremes at
    // both ends; the rest exercise pointer wrap in both directions.
    dir_rows = '{
      '{ideq_pkg::OP_POP_FRONT,  32'h1234_5678, 1'b1,
        outcome(32'h0, ideq_pkg::ST_UNDER, 7'd0, 1'b1, 32'h0, 32'h0)},
      '{ideq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
        outcome(32'h0, ideq_pkg::ST_UNDER, 7'd0, 1'b1, 32'h0, 32'h0)},
      '{ideq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
        outcome(32'h0, ideq_pkg::ST_OK, 7'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF)},
      '{ideq_pkg::OP_PUSH_BACK,  32'h8000_0000, 1'b1,
        outcome(32'h0, ideq_pkg::ST_OK, 7'd2, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000)},
      '{ideq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
        outcome(32'h7FFF_FFFF, ideq_pkg::ST_OK, 7'd1, 1'b0,
                32'h8000_0000, 32'h8000_0000)},
      '{ideq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
        outcome(32'h8000_0000, ideq_pkg::ST_OK, 7'd0, 1'b1, 32'h0, 32'h0)},
      '{ideq_pkg::OP_POP_BACK,   32'h0F0F_0F0F, 1'b1,
        outcome(32'h0, ideq_pkg::ST_UNDER, 7'd0, 1'b1, 32'h0, 32'h0)},
      '{ideq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0, UNTYPED},
      '{ideq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{ideq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1'b0, UNTYPED},
      '{ideq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_BACK,   32'hAAAA_AAAA, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_FRONT,  32'h5555_5555, 1'b0, UNTYPED},
      '{ideq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, UNTYPED},
      '{ideq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_BACK,   32'h8000_0000, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_FRONT,  32'h7FFF_FFFF, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_FRONT,  32'hC3C3_C3C3, 1'b1,
        outcome(32'h0, ideq_pkg::ST_UNDER, 7'd0, 1'b1, 32'h0, 32'h0)},
      '{ideq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, UNTYPED},
      '{ideq_pkg::OP_POP_BACK,   32'h3C3C_3C3C, 1'b0, UNTYPED}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                dir_rows[i].want);

    // Random phases: the first one mostly pushes to fill the queue, later ones
    // pick a mix so that both full and empty are reached again and again.
    sent = 0;
    mix  = MIX_FILL;
    while (sent < N_RANDOM) begin
      span = $urandom_range(30, 120);
      repeat (span) begin
        case (mix)
          MIX_FILL:
            op = ($urandom_range(0, 99) < 85) ? ideq_pkg::op_e'($urandom_range(0, 1))
                                              : ideq_pkg::op_e'($urandom_range(2, 3));
          MIX_DRAIN:
            op = ($urandom_range(0, 99) < 85) ? ideq_pkg::op_e'($urandom_range(2, 3))
                                              : ideq_pkg::op_e'($urandom_range(0, 1));
          default:
            op = ideq_pkg::op_e'($urandom_range(0, 3));
        endcase
        send_item(op, pick_value(), 1'b0, UNTYPED);
        sent++;
      end
      mix = mix_e'($urandom_range(0, 2));
    end

    // Let every result come back, then watch a little longer for strays.
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/ideq_pkg.sv
src/ideq_ctrl.sv
src/ideq_dpath.sv
src/integer_deque.sv
tb/tb.sv
